// ===== src/keypad_debounce_single_shot_defines.svh =====
// ----------------------------------------------------------------------------
// Keypad debounce assertion macros
// Shared property macros for the keypad debounce block checks.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_DEBOUNCE_SINGLE_SHOT_DEFINES_SVH
`define KEYPAD_DEBOUNCE_SINGLE_SHOT_DEFINES_SVH

// Same-cycle implication on aclk under active-low aresetn
`define KDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk under active-low aresetn
`define KDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kds_pkg.sv =====
// ----------------------------------------------------------------------------
// kds_pkg
// Types, key codes and the character table for the keypad debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package kds_pkg;

    localparam int KEY_COUNT      = 12;
    localparam int MATRIX_W       = 12;
    localparam int TIME_W         = 32;
    localparam int DEBOUNCE_W     = 16;
    localparam int CHAR_W         = 8;
    localparam int DELTA_W        = 2;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd25;

    // Key code: 0 = none, 1..12 = key index + 1
    typedef logic [3:0] kds_key_t;

    localparam kds_key_t KEY_NONE = 4'd0;
    localparam kds_key_t KEY_STAR = 4'd10;
    localparam kds_key_t KEY_HASH = 4'd12;

    localparam logic signed [DELTA_W-1:0] NAV_UP   = 2'sb01;
    localparam logic signed [DELTA_W-1:0] NAV_DOWN = 2'sb11;
    localparam logic signed [DELTA_W-1:0] NAV_NONE = 2'sb00;

    // Row-major layout: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
    localparam logic [CHAR_W-1:0] KEY_CHARS [KEY_COUNT] = '{
        8'h31, 8'h32, 8'h33,
        8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39,
        8'h2A, 8'h30, 8'h23
    };

    typedef struct packed {
        logic [MATRIX_W-1:0] pressed_matrix;
        logic [TIME_W-1:0]   now_ms;
    } kds_item_t;

    typedef struct packed {
        logic                       key_valid;
        logic [CHAR_W-1:0]          key_char;
        logic                       nav_valid;
        logic signed [DELTA_W-1:0]  nav_delta;
    } kds_result_t;

    // Lowest set bit wins
    function automatic kds_key_t first_key(input logic [MATRIX_W-1:0] matrix);
        kds_key_t k;
        k = KEY_NONE;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (matrix[i]) begin
                k = kds_key_t'(i + 1);
            end
        end
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] key_to_char(input kds_key_t k);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (k != KEY_NONE) begin
            ch = KEY_CHARS[4'(k - 4'd1)];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/kds_in_stage.sv =====
// ----------------------------------------------------------------------------
// kds_in_stage
// Input register for poll beats; refills in the cycle it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module kds_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [kds_pkg::IN_TDATA_W-1:0] s_tdata,  // [11:0] pressed_matrix,
                                                          // [43:12] now_ms, [47:44] zero
    input  wire logic                           take,
    output logic                                item_valid,
    output kds_pkg::kds_item_t                  item
);
    import kds_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    kds_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.pressed_matrix <= s_tdata[MATRIX_W-1:0];
            item_reg.now_ms         <= s_tdata[MATRIX_W+TIME_W-1:MATRIX_W];
        end
    end

endmodule

`default_nettype wire

// ===== src/kds_core.sv =====
// ----------------------------------------------------------------------------
// kds_core
// Key pick, debounce timing and single-shot latch; state advances per poll.
// ----------------------------------------------------------------------------
`default_nettype none

module kds_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [kds_pkg::DEBOUNCE_W-1:0]  cfg_data,
    input  wire logic                            fire,
    input  wire kds_pkg::kds_item_t              item,
    output kds_pkg::kds_result_t                 result
);
    import kds_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    kds_key_t              reported_reg;
    kds_key_t              reported_next;
    kds_key_t              candidate_reg;
    kds_key_t              candidate_next;
    logic [TIME_W-1:0]     since_reg;
    logic [TIME_W-1:0]     since_next;

    kds_key_t              k;
    logic [TIME_W-1:0]     elapsed;
    logic                  emit;

    assign k       = first_key(item.pressed_matrix);
    assign elapsed = item.now_ms - since_reg;

    always_comb begin
        reported_next  = reported_reg;
        candidate_next = candidate_reg;
        since_next     = since_reg;
        emit           = 1'b0;
        if (k == KEY_NONE) begin
            reported_next  = KEY_NONE;
            candidate_next = KEY_NONE;
        end else if (k == reported_reg) begin
            candidate_next = KEY_NONE;
        end else if (k != candidate_reg) begin
            // new candidate: restart timing
            candidate_next = k;
            since_next     = item.now_ms;
        end else if (elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_reg}) begin
            reported_next  = k;
            candidate_next = KEY_NONE;
            emit           = 1'b1;
        end
    end

    always_comb begin
        result.key_valid = emit;
        result.key_char  = emit ? key_to_char(k) : '0;
        result.nav_valid = emit && (k == KEY_HASH || k == KEY_STAR);
        result.nav_delta = NAV_NONE;
        if (emit && k == KEY_HASH) begin
            result.nav_delta = NAV_UP;
        end else if (emit && k == KEY_STAR) begin
            result.nav_delta = NAV_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RESET;
            reported_reg  <= KEY_NONE;
            candidate_reg <= KEY_NONE;
            since_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                debounce_reg <= cfg_data;
            end
            if (fire) begin
                reported_reg  <= reported_next;
                candidate_reg <= candidate_next;
                since_reg     <= since_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/kds_out_stage.sv =====
// ----------------------------------------------------------------------------
// kds_out_stage
// Result register; loads a new beat while the current one is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kds_out_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 take,
    input  wire kds_pkg::kds_result_t            result,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [kds_pkg::OUT_TDATA_W-1:0]      m_tdata  // [0] key_valid, [8:1] key_char,
                                                          // [9] nav_valid, [11:10] nav_delta,
                                                          // [15:12] zero
);
    import kds_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [OUT_TDATA_W-1:0] data_reg;

    assign take     = in_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= {4'b0000, result.nav_delta, result.nav_valid,
                         result.key_char, result.key_valid};
        end
    end

endmodule

`default_nettype wire

// ===== src/keypad_debounce_single_shot.sv =====
// Datapath: an accepted poll beat is held in the input register, then its
//   result is loaded into the result register and driven on m_tdata.
// Throughput: 1 poll per cycle while m_tready is high; key pick, wrapped time
//   subtract and compare fit between the input register and the result register.
// Reset: synchronous active-low aresetn clears both stages, the key latch and
//   candidate, and loads debounce_ms with 25.
// ----------------------------------------------------------------------------
// keypad_debounce_single_shot
// Debounced single-shot reader for a 4x3 keypad with '#'/'*' navigation.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_single_shot (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kds_pkg::DEBOUNCE_W-1:0]  cfg_data,   // debounce_ms
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [kds_pkg::IN_TDATA_W-1:0]  s_tdata,    // [11:0] pressed_matrix,
                                                             // [43:12] now_ms, [47:44] zero
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [kds_pkg::OUT_TDATA_W-1:0]      m_tdata     // [0] key_valid, [8:1] key_char,
                                                             // [9] nav_valid,
                                                             // [11:10] nav_delta, [15:12] zero
);
    import kds_pkg::*;
`include "keypad_debounce_single_shot_defines.svh"

    logic        item_valid;
    logic        take;
    logic        event_beat;
    kds_item_t   item;
    kds_result_t result;

    assign cfg_ready  = 1'b1;
    assign event_beat = take && result.key_valid;

    kds_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    kds_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .fire      (take),
        .item      (item),
        .result    (result)
    );

    kds_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (item_valid),
        .take     (take),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `KDS_ASSERT_NEXT(a_in_loaded, s_tvalid && s_tready, item_valid, "poll beat lost at input")
    `KDS_ASSERT_NEXT(a_out_loaded, take, m_tvalid, "processed poll gave no result")
    `KDS_ASSERT_NEXT(a_event_kept, event_beat, m_tdata[0] && (|m_tdata[8:1]), "key event dropped")
    `KDS_ASSERT_NOW(a_take_ready, take, item_valid, "result taken without a poll")

endmodule

`default_nettype wire
